>>> hw/rtl/cmm_pkg.sv
// Package for the complex Q16 matrix multiplier.
// Field widths, opcode and register codes, pipeline tag and result types.
// No dependencies.
package cmm_pkg;

    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;
    localparam int SHIFT_W = 5;
    localparam int DATA_W  = 16;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd3;

    // travels with each inner-product term through the datapath
    typedef struct packed {
        logic             first;
        logic             last;
        logic             zero;
        logic             elast;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     elast;
    } t_res;

endpackage

>>> hw/rtl/cmm_in_if.sv
// Input channel of the complex matrix multiplier: valid/ready plus command payload.
// Depends on cmm_pkg.
interface cmm_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic [cmm_pkg::IDX_W-1:0]           row_index;
    logic [cmm_pkg::IDX_W-1:0]           col_index;
    logic signed [cmm_pkg::DATA_W-1:0]   real_part;
    logic signed [cmm_pkg::DATA_W-1:0]   imag_part;

    modport source (output valid, opcode, row_index, col_index, real_part, imag_part,
                    input ready);
    modport sink   (input valid, opcode, row_index, col_index, real_part, imag_part,
                    output ready);
endinterface

>>> hw/rtl/cmm_out_if.sv
// Result channel of the complex matrix multiplier: valid/ready plus one C element.
// Depends on cmm_pkg.
interface cmm_out_if;
    logic                                valid;
    logic                                ready;
    logic [cmm_pkg::IDX_W-1:0]           out_row;
    logic [cmm_pkg::IDX_W-1:0]           out_col;
    logic signed [cmm_pkg::DATA_W-1:0]   out_real;
    logic signed [cmm_pkg::DATA_W-1:0]   out_imag;
    logic                                last_result;

    modport source (output valid, out_row, out_col, out_real, out_imag, last_result,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_real, out_imag, last_result,
                    output ready);
endinterface

>>> hw/rtl/cmm_ram.sv
// Simple dual-port matrix store: one write port, one read port, registered read data.
// No dependencies.
module cmm_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cmm_mac.sv
// Complex multiply, per-product rounding shift and 32-bit accumulate pipeline.
// Depends on cmm_pkg; fed by the two cmm_ram read ports and the sequencer tag.
module cmm_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cmm_pkg::SHIFT_W-1:0]   i_shift,
    input  logic [cmm_pkg::WORD_W-1:0]    i_rd_a,
    input  logic [cmm_pkg::WORD_W-1:0]    i_rd_b,
    input  logic                          i_tag_v,
    input  cmm_pkg::t_tag                 i_tag,
    output logic                          o_res_v,
    output cmm_pkg::t_res                 o_res
);
    import cmm_pkg::*;

    logic signed [DATA_W-1:0] w_ar, w_ai, w_br, w_bi;
    logic signed [WORD_W-1:0] r_prr, r_pii, r_pri, r_pir;
    logic signed [WORD_W-1:0] r_pr, r_pi;
    logic signed [WORD_W-1:0] r_qr, r_qi;
    logic signed [WORD_W-1:0] r_acc_re, r_acc_im;
    logic signed [WORD_W-1:0] n_acc_re, n_acc_im;
    logic [WORD_W-1:0]        w_rnd;
    logic                     r_v1, r_v2, r_v3, r_res_v;
    t_tag                     r_t1, r_t2, r_t3;
    t_res                     r_res;

    assign w_ar = i_rd_a[DATA_W-1:0];
    assign w_ai = i_rd_a[WORD_W-1:DATA_W];
    assign w_br = i_rd_b[DATA_W-1:0];
    assign w_bi = i_rd_b[WORD_W-1:DATA_W];

    assign w_rnd = (i_shift == '0) ? '0 : (WORD_W'(1) << (i_shift - SHIFT_W'(1)));

    always_comb begin
        n_acc_re = (r_t3.first ? '0 : r_acc_re) + (r_t3.zero ? '0 : r_qr);
        n_acc_im = (r_t3.first ? '0 : r_acc_im) + (r_t3.zero ? '0 : r_qi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            r_v1    <= i_tag_v;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_res_v <= r_v3 && r_t3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1  <= i_tag;
        r_prr <= w_ar * w_br;
        r_pii <= w_ai * w_bi;
        r_pri <= w_ar * w_bi;
        r_pir <= w_ai * w_br;

        r_t2 <= r_t1;
        r_pr <= r_prr - r_pii;
        r_pi <= r_pri + r_pir;

        r_t3 <= r_t2;
        r_qr <= $signed(r_pr + w_rnd) >>> i_shift;
        r_qi <= $signed(r_pi + w_rnd) >>> i_shift;

        if (r_v3) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
        r_res.row   <= r_t3.row;
        r_res.col   <= r_t3.col;
        r_res.re    <= n_acc_re[DATA_W-1:0];
        r_res.im    <= n_acc_im[DATA_W-1:0];
        r_res.elast <= r_t3.elast;
    end

    assign o_res_v = r_res_v;
    assign o_res   = r_res;

endmodule

>>> hw/rtl/complex_matrix_multiply_q16.sv
// Top level of the complex Q16 matrix multiplier: config registers, sequencer, output reg.
// Depends on cmm_pkg, cmm_in_if, cmm_out_if, cmm_ram and cmm_mac.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        opcode, row_index, col_index, real_part, imag_part
//   o_out     out  valid/ready        out_row, out_col, out_real, out_imag, last_result
//   i_cfg_*   in   write enable only  register index, data
//
// Loads and opcode 3 are accepted when idle, also while a result waits in the output reg.
// Compute: per C element max(inner,1) store reads (one A and one B read port), then the
// multiply/round/accumulate pipe through to the output reg.
// A new element starts only once the previous result has been taken; i_in stays
// not-ready for the whole compute. Reset clears control state only; stores are unset.
module complex_matrix_multiply_q16 #(
    parameter int MAX_DIM = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cmm_in_if.sink                          i_in,
    cmm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cmm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [CNT_W-1:0]   r_rows, r_inner, r_cols;
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   w_rows, w_inner, w_cols;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_m, r_o, r_n, n_m, n_o, n_n;
    logic             r_fin, n_fin;

    logic              w_in_acc, w_load_ok, w_issue, w_term_last, w_elem_last;
    logic              w_row_last, w_col_last;
    logic [ADDR_W-1:0] w_waddr, w_a_addr, w_b_addr;
    logic [WORD_W-1:0] w_wdata, w_rd_a, w_rd_b;
    logic              r_tag_v;
    t_tag              r_tag;
    logic              w_res_v;
    t_res              w_res;
    logic              r_out_valid;
    t_res              r_out;

    assign w_rows  = (r_rows  > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : r_rows;
    assign w_inner = (r_inner > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : r_inner;
    assign w_cols  = (r_cols  > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CNT_W'(8);
            r_inner <= CNT_W'(8);
            r_cols  <= CNT_W'(8);
            r_shift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS:  r_rows  <= i_cfg_data[CNT_W-1:0];
                CFG_INNER: r_inner <= i_cfg_data[CNT_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[CNT_W-1:0];
                CFG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // loads
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load_ok  = (CNT_W'(i_in.row_index) < CNT_W'(MAX_DIM))
                     && (CNT_W'(i_in.col_index) < CNT_W'(MAX_DIM));
    assign w_waddr = ADDR_W'(int'(i_in.row_index) * MAX_DIM + int'(i_in.col_index));
    assign w_wdata = {i_in.imag_part, i_in.real_part};

    // A is read along row m, B along column o
    assign w_a_addr = ADDR_W'(int'(r_m) * MAX_DIM + int'(r_n));
    assign w_b_addr = ADDR_W'(int'(r_n) * MAX_DIM + int'(r_o));

    cmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(WORD_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_load_ok && (i_in.opcode == OP_LOAD_A)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_a_addr),
        .o_rdata (w_rd_a)
    );

    cmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(WORD_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_load_ok && (i_in.opcode == OP_LOAD_B)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_b_addr),
        .o_rdata (w_rd_b)
    );

    // sequencer
    assign w_term_last = (w_inner == '0) || ((CNT_W'(r_n) + CNT_W'(1)) == w_inner);
    assign w_row_last  = (CNT_W'(r_m) + CNT_W'(1)) == w_rows;
    assign w_col_last  = (CNT_W'(r_o) + CNT_W'(1)) == w_cols;
    assign w_elem_last = w_row_last && w_col_last;

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_o     = r_o;
        n_n     = r_n;
        n_fin   = r_fin;
        w_issue = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.opcode == OP_COMPUTE)
                    && (w_rows != '0) && (w_cols != '0)) begin
                    n_m     = '0;
                    n_o     = '0;
                    n_n     = '0;
                    n_fin   = 1'b0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (!((r_n == '0) && r_out_valid)) begin
                    w_issue = 1'b1;
                    if (w_term_last) begin
                        n_n     = '0;
                        n_state = S_DRAIN;
                        if (w_col_last) begin
                            n_o = '0;
                            if (w_row_last) begin
                                n_fin = 1'b1;
                            end else begin
                                n_m = r_m + IDX_W'(1);
                            end
                        end else begin
                            n_o = r_o + IDX_W'(1);
                        end
                    end else begin
                        n_n = r_n + IDX_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (w_res_v) begin
                    n_state = r_fin ? S_IDLE : S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_m     <= '0;
            r_o     <= '0;
            r_n     <= '0;
            r_fin   <= 1'b0;
            r_tag_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_o     <= n_o;
            r_n     <= n_n;
            r_fin   <= n_fin;
            r_tag_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag.first <= (r_n == '0);
        r_tag.last  <= w_term_last;
        r_tag.zero  <= (w_inner == '0);
        r_tag.elast <= w_elem_last;
        r_tag.row   <= r_m;
        r_tag.col   <= r_o;
    end

    cmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_shift),
        .i_rd_a  (w_rd_a),
        .i_rd_b  (w_rd_b),
        .i_tag_v (r_tag_v),
        .i_tag   (r_tag),
        .o_res_v (w_res_v),
        .o_res   (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_v) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_v) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_row     = r_out.row;
    assign o_out.out_col     = r_out.col;
    assign o_out.out_real    = r_out.re;
    assign o_out.out_imag    = r_out.im;
    assign o_out.last_result = r_out.elast;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_v |-> !r_out_valid)
        else $error("result arrived while output register full");

    a_res_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_v |-> (r_state == S_DRAIN))
        else $error("result arrived outside drain");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_v && w_res.elast) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final element");

endmodule
